@@ design/pgu_pkg.sv @@
`timescale 1ns / 1ps

package pgu_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int LR_W      = 31;

    // datapath widths
    localparam int PRODX_W = LR_W + DATA_W;          // full product
    localparam int PROD_W  = PRODX_W - FRAC_BITS;    // product after the Q shift
    localparam int MAG_W   = PROD_W + 1;             // |value -/+ product|
    localparam int P_W     = MAG_W + 1;              // signed sum
    localparam int D_W     = PROD_W + 1;             // divisor
    localparam int QBITS   = DATA_W;                 // quotient bits kept
    localparam int OVF_SH  = QBITS - FRAC_BITS;      // quotient >= 2^QBITS test

    // register file
    localparam int APB_W  = 32;
    localparam int ADDR_W = 4;
    localparam int IDX_W  = 2;
    localparam logic [IDX_W-1:0] REG_LR = 2'd0;
    localparam logic [IDX_W-1:0] REG_L1 = 2'd1;
    localparam logic [IDX_W-1:0] REG_L2 = 2'd2;

    localparam logic [LR_W-1:0]   LR_RESET = LR_W'(64'd1 << FRAC_BITS);
    localparam logic [D_W-1:0]    D_ONE    = D_W'(64'd1 << FRAC_BITS);
    localparam logic [DATA_W-1:0] SAT_POS  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_NEG  = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

@@ design/proximal_gradient_update_core.sv @@
`timescale 1ns / 1ps
// Proximal gradient update: p = v - alpha*g, L1 soft threshold, divide by 1 + alpha*L2.
// Pipeline: 6 front stages, 32 divide stages, output register.
// Throughput: one item per cycle while the output is not stalled.
// The 32-stage restoring divider retires one quotient bit per stage.
// Reset: synchronous active-low; clears all valid bits and loads alpha = 1.0, L1 = L2 = 0.
module proximal_gradient_update_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [pgu_pkg::DATA_W-1:0]     i_param_value,
    input  logic signed [pgu_pkg::DATA_W-1:0]     i_gradient,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [pgu_pkg::DATA_W-1:0]     o_new_value,
    output logic                                  o_saturated,
    // register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic        [pgu_pkg::ADDR_W-1:0]     paddr,
    input  logic        [pgu_pkg::APB_W-1:0]      pwdata,
    output logic        [pgu_pkg::APB_W-1:0]      prdata,
    output logic                                  pready
);

    // ------------------------------------------------------------------
    // Configuration registers and derived constants
    // ------------------------------------------------------------------
    logic        [pgu_pkg::LR_W-1:0]   r_lr;
    logic signed [pgu_pkg::DATA_W-1:0] r_l1;
    logic        [pgu_pkg::LR_W-1:0]   r_l2;

    // threshold alpha*L1 (zero when L1 is not positive) and divisor 1 + alpha*L2,
    // both registered, so they follow a register write in the next cycle
    logic [pgu_pkg::PROD_W-1:0]  r_thr;
    logic [pgu_pkg::D_W-1:0]     r_div;
    logic [pgu_pkg::PRODX_W-1:0] w_thrx;
    logic [pgu_pkg::PRODX_W-1:0] w_decx;
    logic                        w_l1_pos;

    logic                        w_wr;
    logic [pgu_pkg::IDX_W-1:0]   w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[pgu_pkg::IDX_W+1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= pgu_pkg::LR_RESET;
            r_l1 <= '0;
            r_l2 <= '0;
        end else if (w_wr) begin
            case (w_idx)
                pgu_pkg::REG_LR: r_lr <= pwdata[pgu_pkg::LR_W-1:0];
                pgu_pkg::REG_L1: r_l1 <= pwdata[pgu_pkg::DATA_W-1:0];
                pgu_pkg::REG_L2: r_l2 <= pwdata[pgu_pkg::LR_W-1:0];
                default: ;   // unmapped, write dropped
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            pgu_pkg::REG_LR: prdata = pgu_pkg::APB_W'(r_lr);
            pgu_pkg::REG_L1: prdata = pgu_pkg::APB_W'(r_l1);
            pgu_pkg::REG_L2: prdata = pgu_pkg::APB_W'(r_l2);
            default:         prdata = '0;
        endcase
    end

    assign w_l1_pos = !r_l1[pgu_pkg::DATA_W-1] && (r_l1 != '0);
    assign w_thrx   = pgu_pkg::PRODX_W'(r_lr) * pgu_pkg::PRODX_W'(r_l1[pgu_pkg::DATA_W-2:0]);
    assign w_decx   = pgu_pkg::PRODX_W'(r_lr) * pgu_pkg::PRODX_W'(r_l2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
            r_div <= pgu_pkg::D_ONE;
        end else begin
            r_thr <= w_l1_pos ? pgu_pkg::PROD_W'(w_thrx >> pgu_pkg::FRAC_BITS) : '0;
            r_div <= pgu_pkg::D_ONE + pgu_pkg::D_W'(w_decx >> pgu_pkg::FRAC_BITS);
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipe freezes only while a result is held
    // at the output. The entry stage still fills when it is empty.
    // ------------------------------------------------------------------
    logic w_adv;
    logic w_ld0;
    logic r_out_valid;
    logic r0_vld;

    assign w_adv      = !(r_out_valid && i_out_stall);
    assign w_ld0      = w_adv || !r0_vld;
    assign o_in_stall = !w_ld0;

    // ------------------------------------------------------------------
    // Stage 0: capture, gradient sign/magnitude
    // ------------------------------------------------------------------
    logic signed [pgu_pkg::DATA_W-1:0] r0_v;
    logic                              r0_gneg;
    logic        [pgu_pkg::DATA_W-1:0] r0_gmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_ld0) begin
            r0_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld0) begin
            r0_v    <= i_param_value;
            r0_gneg <= i_gradient[pgu_pkg::DATA_W-1];
            r0_gmag <= i_gradient[pgu_pkg::DATA_W-1] ? (~i_gradient + 1'b1) : i_gradient;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: alpha * |g|, truncated to Q format
    // Stage 2: p = v -/+ product
    // Stage 3: sign and magnitude of p
    // Stage 4: L1 soft threshold (threshold is zero when L1 is off)
    // Stage 5: overflow test and divider setup
    // ------------------------------------------------------------------
    logic                               r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    logic signed [pgu_pkg::DATA_W-1:0]  r1_v;
    logic                               r1_gneg;
    logic        [pgu_pkg::PROD_W-1:0]  r1_prod;
    logic signed [pgu_pkg::P_W-1:0]     r2_p;
    logic                               r3_neg, r4_neg;
    logic        [pgu_pkg::MAG_W-1:0]   r3_mag, r4_mag;

    logic        [pgu_pkg::PRODX_W-1:0] w_prodx;
    logic signed [pgu_pkg::P_W-1:0]     w_vext;
    logic signed [pgu_pkg::P_W-1:0]     w_pext;
    logic        [pgu_pkg::MAG_W-1:0]   w_thr_ext;
    logic        [pgu_pkg::MAG_W-1:0]   w_hi;      // mag >> OVF_SH
    logic                               w_ovf;

    assign w_prodx   = pgu_pkg::PRODX_W'(r0_gmag) * pgu_pkg::PRODX_W'(r_lr);
    assign w_vext    = pgu_pkg::P_W'(r1_v);
    assign w_pext    = signed'({{(pgu_pkg::P_W-pgu_pkg::PROD_W){1'b0}}, r1_prod});
    assign w_thr_ext = pgu_pkg::MAG_W'(r_thr);
    assign w_hi      = r4_mag >> pgu_pkg::OVF_SH;
    // quotient >= 2^QBITS  <=>  floor(mag / 2^OVF_SH) >= d
    assign w_ovf     = (w_hi >= pgu_pkg::MAG_W'(r_div));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_v    <= r0_v;
            r1_gneg <= r0_gneg;
            r1_prod <= pgu_pkg::PROD_W'(w_prodx >> pgu_pkg::FRAC_BITS);

            r2_p    <= r1_gneg ? (w_vext + w_pext) : (w_vext - w_pext);

            r3_neg  <= r2_p[pgu_pkg::P_W-1];
            r3_mag  <= pgu_pkg::MAG_W'(r2_p[pgu_pkg::P_W-1] ? -r2_p : r2_p);

            r4_neg  <= r3_neg;
            r4_mag  <= (r3_mag > w_thr_ext) ? (r3_mag - w_thr_ext) : '0;
        end
    end

    // divider setup state: sign, overflow flag, remainder, dividend bits still to shift in
    logic                        r5_neg, r5_ovf;
    logic [pgu_pkg::D_W-1:0]     r5_rem;
    logic [pgu_pkg::QBITS-1:0]   r5_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_adv) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_neg <= r4_neg;
            r5_ovf <= w_ovf;
            // on overflow the quotient is discarded; start from zero to keep rem < d
            r5_rem <= w_ovf ? '0 : pgu_pkg::D_W'(w_hi);
            r5_low <= {r4_mag[pgu_pkg::OVF_SH-1:0], {pgu_pkg::FRAC_BITS{1'b0}}};
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------
    logic                      r_dv_vld [pgu_pkg::QBITS];
    logic                      r_dv_neg [pgu_pkg::QBITS];
    logic                      r_dv_ovf [pgu_pkg::QBITS];
    logic [pgu_pkg::D_W-1:0]   r_dv_rem [pgu_pkg::QBITS];
    logic [pgu_pkg::QBITS-1:0] r_dv_low [pgu_pkg::QBITS];
    logic [pgu_pkg::QBITS-1:0] r_dv_quo [pgu_pkg::QBITS];

    logic [pgu_pkg::D_W-1:0]   n_dv_rem [pgu_pkg::QBITS];
    logic [pgu_pkg::QBITS-1:0] n_dv_low [pgu_pkg::QBITS];
    logic [pgu_pkg::QBITS-1:0] n_dv_quo [pgu_pkg::QBITS];

    always_comb begin
        logic [pgu_pkg::D_W:0]     t;
        logic [pgu_pkg::D_W-1:0]   rem_in;
        logic [pgu_pkg::QBITS-1:0] low_in;
        logic [pgu_pkg::QBITS-1:0] quo_in;
        for (int k = 0; k < pgu_pkg::QBITS; k++) begin
            if (k == 0) begin
                rem_in = r5_rem;
                low_in = r5_low;
                quo_in = '0;
            end else begin
                rem_in = r_dv_rem[k-1];
                low_in = r_dv_low[k-1];
                quo_in = r_dv_quo[k-1];
            end
            t = {rem_in, low_in[pgu_pkg::QBITS-1]};
            if (t >= {1'b0, r_div}) begin
                n_dv_rem[k] = pgu_pkg::D_W'(t - {1'b0, r_div});
                n_dv_quo[k] = {quo_in[pgu_pkg::QBITS-2:0], 1'b1};
            end else begin
                n_dv_rem[k] = pgu_pkg::D_W'(t);
                n_dv_quo[k] = {quo_in[pgu_pkg::QBITS-2:0], 1'b0};
            end
            n_dv_low[k] = {low_in[pgu_pkg::QBITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < pgu_pkg::QBITS; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_dv_vld[0] <= r5_vld;
            for (int k = 1; k < pgu_pkg::QBITS; k++) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_neg[0] <= r5_neg;
            r_dv_ovf[0] <= r5_ovf;
            for (int k = 1; k < pgu_pkg::QBITS; k++) begin
                r_dv_neg[k] <= r_dv_neg[k-1];
                r_dv_ovf[k] <= r_dv_ovf[k-1];
            end
            for (int k = 0; k < pgu_pkg::QBITS; k++) begin
                r_dv_rem[k] <= n_dv_rem[k];
                r_dv_low[k] <= n_dv_low[k];
                r_dv_quo[k] <= n_dv_quo[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sign and saturation, output register
    // ------------------------------------------------------------------
    logic [pgu_pkg::QBITS-1:0]  w_q;
    logic                       w_fneg, w_fovf;
    logic [pgu_pkg::DATA_W-1:0] n_out_value;
    logic                       n_out_sat;
    logic [pgu_pkg::DATA_W-1:0] r_out_value;
    logic                       r_out_sat;

    assign w_q    = r_dv_quo[pgu_pkg::QBITS-1];
    assign w_fneg = r_dv_neg[pgu_pkg::QBITS-1];
    assign w_fovf = r_dv_ovf[pgu_pkg::QBITS-1];

    always_comb begin
        if (w_fneg) begin
            // negative side reaches one further
            if (w_fovf || (w_q > pgu_pkg::SAT_NEG)) begin
                n_out_value = pgu_pkg::SAT_NEG;
                n_out_sat   = 1'b1;
            end else begin
                n_out_value = ~w_q + 1'b1;
                n_out_sat   = 1'b0;
            end
        end else begin
            if (w_fovf || w_q[pgu_pkg::QBITS-1]) begin
                n_out_value = pgu_pkg::SAT_POS;
                n_out_sat   = 1'b1;
            end else begin
                n_out_value = w_q;
                n_out_sat   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_dv_vld[pgu_pkg::QBITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_value <= n_out_value;
            r_out_sat   <= n_out_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_new_value = r_out_value;
    assign o_saturated = r_out_sat;

`ifndef NO_ASSERTIONS
    // a clipped result is always one of the two range limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_new_value == pgu_pkg::SAT_POS || o_new_value == pgu_pkg::SAT_NEG))
        else $error("saturated result is not a range limit");

    // restoring divider invariant at the last bit
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[pgu_pkg::QBITS-1] |-> (r_dv_rem[pgu_pkg::QBITS-1] < r_div))
        else $error("divider remainder not below divisor");

    // input side only backs up when the output holds an untaken result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && r0_vld))
        else $error("input stalled without a held result");

    // frozen pipe keeps the item at the head
    a_freeze_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_new_value)))
        else $error("held result lost while frozen");
`endif

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAC_BITS = pgu_pkg::FRAC_BITS;
    localparam int DATA_W    = pgu_pkg::DATA_W;
    localparam int LR_W      = pgu_pkg::LR_W;
    localparam int APB_W     = pgu_pkg::APB_W;
    localparam int ADDR_W    = pgu_pkg::ADDR_W;
    localparam int IDX_W     = pgu_pkg::IDX_W;
    localparam logic [IDX_W-1:0] REG_LR = pgu_pkg::REG_LR;
    localparam logic [IDX_W-1:0] REG_L1 = pgu_pkg::REG_L1;
    localparam logic [IDX_W-1:0] REG_L2 = pgu_pkg::REG_L2;

    localparam logic [IDX_W-1:0]  REG_SPARE = 2'd3;   // decoded by nobody
    localparam logic [DATA_W-1:0] MAX_Q     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MIN_Q     = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ONE_Q     = 32'h0001_0000;   // 1.0 in Q16.16
    localparam int                LONG_HOLD = 300;

    typedef struct packed {
        logic [DATA_W-1:0] new_value;
        logic              saturated;
    } t_update;

    // ---------------------------------------------------------------------
    // Clock, reset and DUT-facing signals (all known from time zero)
    // ---------------------------------------------------------------------
    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic [DATA_W-1:0] param_value = '0;
    logic [DATA_W-1:0] gradient    = '0;
    logic              out_stall   = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [APB_W-1:0]  pwdata      = '0;

    logic              in_stall;
    logic              out_valid;
    logic [DATA_W-1:0] new_value;
    logic              saturated;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    // Local copy of the register file, mirrored on every write
    logic [LR_W-1:0]   rate_q  = LR_W'(1 << FRAC_BITS);
    logic [DATA_W-1:0] l1_q    = '0;
    logic [LR_W-1:0]   decay_q = '0;

    t_update expected_updates[$];

    // Test controls and bookkeeping
    bit no_idle      = 1'b0;   // suppresses random gaps and stalls
    int hold_request = 0;      // cycles of output hold asked of the receiver
    int errors       = 0;
    int items_sent   = 0;
    int results_checked = 0;
    int settings_used   = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    proximal_gradient_update_core u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_param_value (param_value),
        .i_gradient    (gradient),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_new_value   (new_value),
        .o_saturated   (saturated),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ---------------------------------------------------------------------
    // Expected update for one element under the current register values.
    // Everything fits in 64 bits: |p| < 2^47, so |p| << 16 < 2^63.
    // ---------------------------------------------------------------------
    function automatic t_update predict_update(input logic [DATA_W-1:0] v,
                                               input logic [DATA_W-1:0] g);
        logic [63:0] alpha, g_mag, step, p_mag, thr, divisor, quot;
        longint      p;
        t_update     r;
        alpha = 64'(rate_q);
        g_mag = g[DATA_W-1] ? 64'(-longint'($signed(g))) : 64'(g);
        // alpha*g truncated on the magnitude, sign put back through the add/sub
        step  = (alpha * g_mag) >> FRAC_BITS;
        p     = g[DATA_W-1] ? longint'($signed(v)) + longint'(step)
                            : longint'($signed(v)) - longint'(step);
        p_mag = (p < 0) ? 64'(-p) : 64'(p);
        // soft threshold only for a positive L1; clamps at zero, never flips sign
        if ($signed(l1_q) > 0) begin
            thr   = (alpha * 64'(l1_q)) >> FRAC_BITS;
            p_mag = (p_mag > thr) ? p_mag - thr : 64'd0;
        end
        divisor = (64'd1 << FRAC_BITS) + ((alpha * 64'(decay_q)) >> FRAC_BITS);
        quot    = (p_mag << FRAC_BITS) / divisor;
        r.saturated = 1'b0;
        if (p < 0) begin
            if (quot > 64'h8000_0000) begin
                quot        = 64'h8000_0000;
                r.saturated = 1'b1;
            end
            r.new_value = DATA_W'(64'd0 - quot);
        end else begin
            if (quot > 64'h7FFF_FFFF) begin
                quot        = 64'h7FFF_FFFF;
                r.saturated = 1'b1;
            end
            r.new_value = DATA_W'(quot);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Random operand: full-range bits, small and mid values, and extremes
    // ---------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2:       return DATA_W'($urandom_range(0, 16 << 16)) - DATA_W'(8 << 16);
            3: begin
                case ($urandom_range(0, 4))
                    0:       return MAX_Q;
                    1:       return MIN_Q;
                    2:       return '0;
                    3:       return '1;
                    default: return 32'd1;
                endcase
            end
            default: return DATA_W'($urandom_range(0, 2048 << 16)) - DATA_W'(1024 << 16);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_rate();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;    // upper bit is dropped by the register
            2:       return DATA_W'($urandom_range(1, 4 << 16));
            3:       return $urandom;
            default: return DATA_W'($urandom_range(1 << 12, 2 << 16));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_l1();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return MIN_Q;
            2:       return MAX_Q;
            3:       return $urandom;
            4:       return DATA_W'(0) - DATA_W'($urandom_range(1, 4 << 16));
            default: return DATA_W'($urandom_range(1, 4 << 16));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_l2();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            default: return DATA_W'($urandom_range(1, 4 << 16));
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Register port: setup cycle, then access cycle until pready, then an idle
    // phase. All register tasks start and end on a falling edge.
    // ---------------------------------------------------------------------
    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [APB_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_LR:  rate_q  = data[LR_W-1:0];
            REG_L1:  l1_q    = data;
            REG_L2:  decay_q = data[LR_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic reg_check(input logic [IDX_W-1:0] idx, input logic [APB_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== want) begin
            $error("register %0d readback: expected %h, actual %h", idx, want, prdata);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_all_regs();
        reg_check(REG_LR, APB_W'(rate_q));
        reg_check(REG_L1, l1_q);
        reg_check(REG_L2, APB_W'(decay_q));
    endtask

    task automatic configure(input logic [DATA_W-1:0] lr, input logic [DATA_W-1:0] l1,
                             input logic [DATA_W-1:0] l2);
        reg_write(REG_LR, lr);
        reg_write(REG_L1, l1);
        reg_write(REG_L2, l2);
        settings_used++;
    endtask

    // ---------------------------------------------------------------------
    // Input side. Called on a falling edge; returns on a falling edge.
    // valid is left high for back-to-back transfers, so each edge sees one write.
    // ---------------------------------------------------------------------
    task automatic send_sample(input logic [DATA_W-1:0] v, input logic [DATA_W-1:0] g);
        int gap;
        in_valid    <= 1'b1;
        param_value <= v;
        gradient    <= g;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_updates.push_back(predict_update(v, g));
        items_sent++;
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stop offering and wait for every outstanding result (registers may then change)
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_updates.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Output side: random stall bursts, plus long holds on request
    // ---------------------------------------------------------------------
    initial begin : output_receiver
        int burst;
        int held;
        burst = 0;
        held  = 0;
        forever begin
            @(negedge clk);
            if (hold_request != 0) begin
                held         = hold_request;
                hold_request = 0;
            end
            if (held > 0) begin
                held--;
                out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                out_stall <= 1'b1;
            end else if (!no_idle && rst_n && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(0, 11);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Every result transfer is matched against the oldest prediction
    always @(posedge clk) begin : check_results
        t_update want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (expected_updates.size() == 0) begin
                $error("result with nothing expected: new_value %h saturated %b",
                       new_value, saturated);
                errors++;
            end else begin
                want = expected_updates.pop_front();
                results_checked++;
                if (new_value !== want.new_value) begin
                    $error("new_value: expected %h, actual %h", want.new_value, new_value);
                    errors++;
                end
                if (saturated !== want.saturated) begin
                    $error("saturated: expected %b, actual %b", want.saturated, saturated);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset values, readback, write masking of the 31-bit registers, spare address
    task automatic test_register_file();
        check_all_regs();
        configure('1, MIN_Q, '1);
        check_all_regs();
        reg_write(REG_SPARE, 32'h1234_5678);
        check_all_regs();
        configure(32'h5555_5555, 32'hAAAA_AAAA, 32'h2AAA_AAAA);
        check_all_regs();
    endtask

    task automatic test_directed_cases();
        // unit step, no regularization: identity, sign handling, both clip directions
        configure(ONE_Q, '0, '0);
        send_sample('0, '0);
        send_sample(MAX_Q, '0);
        send_sample(MIN_Q, '0);
        send_sample('1, '0);
        send_sample(32'd1, '0);
        send_sample('0, MIN_Q);              // 0 + 2^31 clips high
        send_sample('0, MAX_Q);
        send_sample(MIN_Q, ONE_Q);           // one below the floor clips low
        send_sample(MAX_Q, '0 - ONE_Q);      // one above the ceiling
        drain_pipeline();
        // largest step and threshold: shrink past zero, and huge values that survive it
        configure('1, MAX_Q, '0);
        send_sample(ONE_Q, '0);
        send_sample(MIN_Q, '0);
        send_sample(MAX_Q, MIN_Q);
        send_sample(MIN_Q, MAX_Q);
        drain_pipeline();
        // negative L1 is a no-op; largest decay divisor
        configure(ONE_Q, '0 - ONE_Q, '1);
        send_sample(MAX_Q, '0);
        send_sample(MIN_Q, '0);
        send_sample('0, MIN_Q);
        drain_pipeline();
        // zero step: gradient ignored, smallest positive L1 gives zero threshold
        configure('0, 32'd1, '0);
        send_sample(MIN_Q, MAX_Q);
        send_sample(MAX_Q, MIN_Q);
        drain_pipeline();
        // an ordinary half-step with both penalties on
        configure(ONE_Q >> 1, ONE_Q, ONE_Q);
        send_sample(3 << 16, ONE_Q);
        send_sample('0 - (3 << 16), '0 - ONE_Q);
        drain_pipeline();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            configure(rand_rate(), rand_l1(), rand_l2());
            repeat (220) send_sample(rand_operand(), rand_operand());
            drain_pipeline();
        end
    endtask

    // Long output hold fills the pipe and must stall the input; then a full pause
    task automatic test_output_backpressure();
        configure(ONE_Q, 32'h0000_4000, 32'h0000_8000);
        no_idle      = 1'b1;
        hold_request = LONG_HOLD;
        repeat (120) send_sample(rand_operand(), rand_operand());
        no_idle = 1'b0;
        drain_pipeline();
        repeat (40) send_sample(rand_operand(), rand_operand());
        drain_pipeline();
    endtask

    // Back-to-back at full rate, no stalls on either side
    task automatic test_steady_stream();
        configure(rand_rate(), rand_l1(), rand_l2());
        no_idle = 1'b1;
        repeat (100) send_sample(rand_operand(), rand_operand());
        drain_pipeline();
    endtask

    initial begin : run_tests
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_register_file();
        test_directed_cases();
        test_random_settings();
        test_output_backpressure();
        test_steady_stream();

        // let any stray result show up past the end of the pipe
        repeat (60) @(posedge clk);

        $display("Covered %0d input transfers and %0d checked results over %0d settings,",
                 items_sent, results_checked, settings_used);
        $display("incl. register readback, a %0d-cycle output hold and a full-rate tail.",
                 LONG_HOLD);
        if (errors == 0) begin
            $display("[proximal_gradient_update_core] OK");
        end else begin
            $display("[proximal_gradient_update_core] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("[proximal_gradient_update_core] ERROR");
        $finish;
    end

endmodule
